/* design/quadrature_decoder_debounced_macros.svh */
// assertion macros shared by the quadrature decoder rtl
// no dependencies; included by the files that carry assertions
`ifndef QUADRATURE_DECODER_DEBOUNCED_MACROS_SVH
`define QUADRATURE_DECODER_DEBOUNCED_MACROS_SVH

// property checked on every clock edge, switched off while reset is asserted
`define QDD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define QDD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/qdd_pkg.sv */
// shared types and constants of the debounced quadrature decoder
// no dependencies; used by every module of the block
package qdd_pkg;

  localparam int unsigned NowW   = 32;
  localparam int unsigned DebW   = 20;
  localparam int unsigned CfgIdxW = 1;

  // register map of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_OFF_LEVEL   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_US = 1'b1;

  localparam logic            OFF_LEVEL_RST   = 1'b0;
  localparam logic [DebW-1:0] DEBOUNCE_US_RST = DebW'(1000);

  // request kinds
  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_INIT = 1'b1;

  // edge source
  localparam logic PIN_A = 1'b0;
  localparam logic PIN_B = 1'b1;

  // tick direction codes
  localparam logic signed [1:0] DIR_NEG = -2'sd1;
  localparam logic signed [1:0] DIR_POS = 2'sd1;

  typedef struct packed {
    logic            req_type;
    logic            level_a;
    logic            level_b;
    logic [NowW-1:0] now_us;
  } qdd_in_t;

  typedef struct packed {
    logic signed [1:0] direction;
    logic              edge_pin;
  } qdd_out_t;

  typedef struct packed {
    logic            off_level;
    logic [DebW-1:0] debounce_us;
  } qdd_cfg_t;

endpackage

/* design/qdd_cfg_regs.sv */
// configuration registers of the quadrature decoder
// depends on qdd_pkg
module qdd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [qdd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [qdd_pkg::DebW-1:0]     cfg_data_i,
  output qdd_pkg::qdd_cfg_t            cfg_o
);
  import qdd_pkg::*;

  qdd_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OFF_LEVEL:   cfg_d.off_level   = cfg_data_i[0];
        CFG_DEBOUNCE_US: cfg_d.debounce_us = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.off_level   <= OFF_LEVEL_RST;
      cfg_q.debounce_us <= DEBOUNCE_US_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/qdd_core.sv */
// debounce state and tick decision for one pin sample per cycle while en_i is high
// depends on qdd_pkg and the assertion macro header
`include "quadrature_decoder_debounced_macros.svh"

module qdd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  qdd_pkg::qdd_in_t    item_i,
  input  qdd_pkg::qdd_cfg_t   cfg_i,
  output logic                tick_o,
  output qdd_pkg::qdd_out_t   res_o
);
  import qdd_pkg::*;

  logic            stable_a_q, stable_a_d;
  logic            stable_b_q, stable_b_d;
  logic            raw_a_q, raw_a_d;
  logic            raw_b_q, raw_b_d;
  logic [NowW-1:0] change_time_q, change_time_d;

  logic            raw_chg;
  logic [NowW-1:0] stamp;
  logic [NowW-1:0] elapsed;
  logic            follow;
  logic            na, nb;
  logic            a_on, b_on;
  logic            a_edge, b_edge;
  logic            is_init;

  assign is_init = (item_i.req_type == REQ_INIT);

  // any raw change restamps the shared change time
  assign raw_chg = (item_i.level_a != raw_a_q) || (item_i.level_b != raw_b_q);
  assign stamp   = raw_chg ? item_i.now_us : change_time_q;
  assign elapsed = item_i.now_us - stamp;
  assign follow  = (cfg_i.debounce_us == '0) ||
                   (elapsed > {{(NowW-DebW){1'b0}}, cfg_i.debounce_us});

  assign na     = follow ? item_i.level_a : stable_a_q;
  assign nb     = follow ? item_i.level_b : stable_b_q;
  assign a_on   = na ^ cfg_i.off_level;
  assign b_on   = nb ^ cfg_i.off_level;
  assign a_edge = (na != stable_a_q);
  assign b_edge = (nb != stable_b_q);

  always_comb begin
    tick_o = !is_init && (a_edge || b_edge);
    if (a_edge) begin
      res_o.edge_pin  = PIN_A;
      res_o.direction = (a_on == b_on) ? DIR_NEG : DIR_POS;
    end else begin
      res_o.edge_pin  = PIN_B;
      res_o.direction = (a_on == b_on) ? DIR_POS : DIR_NEG;
    end
  end

  always_comb begin
    stable_a_d    = stable_a_q;
    stable_b_d    = stable_b_q;
    raw_a_d       = raw_a_q;
    raw_b_d       = raw_b_q;
    change_time_d = change_time_q;
    if (en_i) begin
      raw_a_d = item_i.level_a;
      raw_b_d = item_i.level_b;
      if (is_init) begin
        stable_a_d    = item_i.level_a;
        stable_b_d    = item_i.level_b;
        change_time_d = item_i.now_us;
      end else begin
        stable_a_d    = na;
        stable_b_d    = nb;
        change_time_d = stamp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_a_q    <= 1'b0;
      stable_b_q    <= 1'b0;
      raw_a_q       <= 1'b0;
      raw_b_q       <= 1'b0;
      change_time_q <= '0;
    end else begin
      stable_a_q    <= stable_a_d;
      stable_b_q    <= stable_b_d;
      raw_a_q       <= raw_a_d;
      raw_b_q       <= raw_b_d;
      change_time_q <= change_time_d;
    end
  end

  `QDD_ASSERT(a_bypass_tracks_raw, clk_i, rst_ni, en_i && (cfg_i.debounce_us == '0) |=> (stable_a_q == raw_a_q) && (stable_b_q == raw_b_q), "stable levels lag raw levels with debounce bypassed")
  `QDD_ASSERT(a_tick_needs_change, clk_i, rst_ni, en_i && tick_o |=> (stable_a_q != $past(stable_a_q)) || (stable_b_q != $past(stable_b_q)), "tick without a stable level change")
  `QDD_ASSERT(a_init_syncs, clk_i, rst_ni, en_i && is_init |=> (stable_a_q == raw_a_q) && (stable_b_q == raw_b_q), "init left stable and raw levels apart")

endmodule

/* design/quadrature_decoder_debounced.sv */
// top level of the debounced quadrature decoder
// depends on qdd_pkg, qdd_cfg_regs, qdd_core and the assertion macro header
//
// usage
//   in channel: one pin sample per transfer (req_type, level_a, level_b, now_us).
//     req_type init loads the debounce state from the sample and gives no result;
//     req_type scan runs the debounce and may give one tick
//   out channel: one tick per transfer (direction -1 or +1, edge_pin A or B)
//   cfg port: index 0 off_level, index 1 debounce_us; always ready, write only
//     while no sample is in flight
//   flow: a sample is taken into the input register and evaluated from there;
//     its tick is registered in the result register and offered on the out channel
//   throughput: one sample per cycle unless out_stall_i holds a tick; a 32-bit
//     subtract and compare against the debounce setting is the whole per-sample path
//   stall: the out register holds a tick while out_stall_i is high; the in
//     register still takes one sample, then in_stall_o rises until the tick
//     drains, so nothing is dropped
//   reset: clears both registers' valid flags and the debounce state; off_level
//     returns to 0 and debounce_us to 1000
`include "quadrature_decoder_debounced_macros.svh"

module quadrature_decoder_debounced (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // sample channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  qdd_pkg::qdd_in_t            in_data_i,
  // tick channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output qdd_pkg::qdd_out_t           out_data_o,
  // configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [qdd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [qdd_pkg::DebW-1:0]    cfg_data_i
);
  import qdd_pkg::*;

  qdd_cfg_t cfg;

  // input register
  logic     in_valid_q, in_valid_d;
  qdd_in_t  in_q;
  // result register
  logic     out_valid_q, out_valid_d;
  qdd_out_t out_q;

  logic     advance;   // result register can take a new value
  logic     proc;      // held sample is evaluated this cycle
  logic     in_xfer;   // input transfer this cycle
  logic     tick;
  qdd_out_t res;

  qdd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  qdd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (proc),
    .item_i (in_q),
    .cfg_i  (cfg),
    .tick_o (tick),
    .res_o  (res)
  );

  // a sample only waits when the result register is full and stalled
  assign advance    = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = proc && tick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
    if (proc && tick) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `QDD_ASSERT(a_stall_only_when_held, clk_i, rst_ni, !in_valid_q |-> !in_stall_o, "input stalled with an empty input register")
  `QDD_ASSERT(a_init_no_tick, clk_i, rst_ni, proc && (in_q.req_type == REQ_INIT) |=> !out_valid_q, "init request produced a tick")
  `QDD_ASSERT(a_dir_code, clk_i, rst_ni, out_valid_q |-> (out_q.direction == DIR_POS) || (out_q.direction == DIR_NEG), "tick with an invalid direction code")
  `QDD_ASSERT_ALWAYS(a_reset_clears, clk_i, !rst_ni |=> !out_valid_o && !in_stall_o, "valid state visible during reset")

endmodule
